### src/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted priority queue and its cells.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DATA_W = 32;
  localparam int RANK_W = 16;
  localparam int HELD_W = 5;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [RANK_W-1:0] rank;
  } entry_t;

  // broadcast to every cell for the transaction being applied
  typedef struct packed {
    logic   push;
    logic   pop;
    entry_t ent;
  } ctrl_t;

endpackage

### src/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue kept sorted in a row of cells, smallest priority first.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one command per transaction:
//   cmd push inserts item_data behind every entry of lower or equal
//   item_priority, cmd pop removes the head. A push into a full queue is
//   dropped and flagged; a pop on an empty queue returns 0 with pop_ok low.
//   Output channel (out_valid / out_stall) returns exactly one result per
//   command: popped data, flags, the new head data, empty flag and count.
//   out_valid rises in the cycle after acceptance. Every cell compares
//   and shifts in parallel as the command is accepted, so one command is
//   taken every cycle while results are drained.
//   The result sits in an output register; while it is stalled in_stall is
//   raised and the queue holds. Reset empties the queue and clears out_valid;
//   cell contents are left as they are and are never read until written.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               cmd,
  input  logic signed [31:0] item_data,
  input  logic        [15:0] item_priority,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] popped_data,
  output logic               pop_ok,
  output logic               push_dropped,
  output logic signed [31:0] head_data,
  output logic               is_empty,
  output logic        [4:0]  entries_held
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = CW + spq_pkg::HELD_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic            accept;
  logic            full;
  logic            nonempty;
  spq_pkg::ctrl_t  ctrl;
  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  logic [EW-1:0]   held_wide;

  logic            tk [CAPACITY+1];
  spq_pkg::entry_t ent [CAPACITY];
  spq_pkg::entry_t right [CAPACITY];
  spq_pkg::entry_t left [CAPACITY];

  logic [31:0]     popped_next;
  logic [31:0]     head_next;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = count == CAP_C;
  assign nonempty = count != '0;

  assign ctrl.push     = accept && (cmd == spq_pkg::CMD_PUSH) && !full;
  assign ctrl.pop      = accept && (cmd == spq_pkg::CMD_POP) && nonempty;
  assign ctrl.ent.data = item_data;
  assign ctrl.ent.rank = item_priority;

  assign tk[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left[i] = ctrl.ent;
    end else begin : g_rest
      assign left[i] = ent[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right[i] = ent[i];
    end else begin : g_inner
      assign right[i] = ent[i+1];
    end

    spq_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .count     (count),
      .left_take (tk[i]),
      .left_ent  (left[i]),
      .right_ent (right[i]),
      .take      (tk[i+1]),
      .ent       (ent[i])
    );
  end

  always_comb begin
    count_next = count;
    if (ctrl.push) begin
      count_next = count + 1'b1;
    end else if (ctrl.pop) begin
      count_next = count - 1'b1;
    end
  end

  assign held_wide = EW'(count_next);

  always_comb begin
    popped_next = '0;
    head_next   = ent[0].data;
    if (ctrl.pop) begin
      popped_next = ent[0].data;
      head_next   = (count > CW'(1)) ? ent[1].data : '0;
    end else if (ctrl.push && tk[1]) begin
      head_next = item_data;
    end else if (!nonempty) begin
      head_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (accept) begin
      popped_data  <= popped_next;
      pop_ok       <= ctrl.pop;
      push_dropped <= (cmd == spq_pkg::CMD_PUSH) && full;
      head_data    <= head_next;
      is_empty     <= count_next == '0;
      entries_held <= held_wide[spq_pkg::HELD_W-1:0];
    end
  end

  // a push into a queue with room grows it by one
  assert property (@(posedge clk) disable iff (rst)
    ctrl.push |=> count == $past(count) + 1'b1)
    else $error("push did not grow the queue");

  assert property (@(posedge clk) disable iff (rst)
    ctrl.pop |=> count == $past(count) - 1'b1)
    else $error("pop did not shrink the queue");

  // the queue only changes on an accepted transaction
  assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(count))
    else $error("count changed without a transaction");

  assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid && (is_empty == (count == '0)))
    else $error("result missing or empty flag wrong");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(pop_ok && push_dropped) && (count <= CAP_C))
    else $error("inconsistent result flags or overfilled queue");

endmodule

### src/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted queue: holds an entry, decides whether the pushed
// entry goes at or before it, and shifts towards or away from the head.
// ----------------------------------------------------------------------------
module spq_cell #(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic            clk,
  input  spq_pkg::ctrl_t  ctrl,
  input  logic [CW-1:0]   count,
  input  logic            left_take,
  input  spq_pkg::entry_t left_ent,
  input  spq_pkg::entry_t right_ent,
  output logic            take,
  output spq_pkg::entry_t ent
);

  localparam logic [CW-1:0] IDX_C = CW'(IDX);

  logic            occupied;
  spq_pkg::entry_t ent_next;

  assign occupied = count > IDX_C;

  // new entry lands at or before this slot
  assign take = ctrl.push && (!occupied || (ent.rank > ctrl.ent.rank));

  always_comb begin
    ent_next = ent;
    if (ctrl.pop) begin
      ent_next = right_ent;
    end else if (take) begin
      if (left_take) begin
        ent_next = left_ent;
      end else begin
        ent_next = ctrl.ent;
      end
    end
  end

  always_ff @(posedge clk) begin
    ent <= ent_next;
  end

endmodule
